[design/ngk_pkg.sv]
package ngk_pkg;

   // Name buffer depth. At most NAME_BUFFER_SIZE-1 bytes of a name are kept.
   localparam int NAME_BUFFER_SIZE = 512;
   localparam int CNT_W            = $clog2(NAME_BUFFER_SIZE);

   // Field widths of the channels.
   localparam int BYTE_W    = 8;
   localparam int HASH_W    = 32;
   localparam int KEY_LEN_W = 9;
   localparam int KBS_W     = 10;

   localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX = '1;
   localparam logic [KBS_W-1:0]     KBS_RESET   = 10'd256;

   // 32-bit FNV-1a constants.
   localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

   // Tail buffer holds the four bytes that may form an extension.
   localparam int TAIL_DEPTH = 4;
   localparam int TAIL_CNT_W = 3;

   // Character codes.
   localparam logic [BYTE_W-1:0] CHAR_NUL        = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_DOT        = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [BYTE_W-1:0] CHAR_L          = 8'h6C;
   localparam logic [BYTE_W-1:0] CHAR_H          = 8'h68;
   localparam logic [BYTE_W-1:0] CHAR_A          = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_Z          = 8'h7A;
   localparam logic [BYTE_W-1:0] CHAR_X          = 8'h78;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_FLUSH,
      ST_FINISH
   } ngk_state_type;

   // Map an upper-case ASCII letter to lower case; other codes pass.
   function automatic logic [BYTE_W-1:0] lower_ascii(input logic [BYTE_W-1:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'd32;
      end
      return c;
   endfunction

   // True for ASCII letters and digits.
   function automatic logic is_alnum_ascii(input logic [BYTE_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

[design/ngk_req_if.sv]
interface ngk_req_if import ngk_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] name_byte;

   modport source (output valid, output name_byte, input ready);
   modport sink (input valid, input name_byte, output ready);
endinterface

[design/ngk_rsp_if.sv]
interface ngk_rsp_if import ngk_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 key_ok;
   logic [HASH_W-1:0]    key_hash;
   logic [KEY_LEN_W-1:0] key_length;

   modport source (output valid, output key_ok, output key_hash, output key_length,
                   input ready);
   modport sink (input valid, input key_ok, input key_hash, input key_length,
                 output ready);
endinterface

[design/ngk_csr_if.sv]
interface ngk_csr_if import ngk_pkg::*;;
   logic             valid;
   logic             ready;
   logic [KBS_W-1:0] key_buffer_size;

   modport source (output valid, output key_buffer_size, input ready);
   modport sink (input valid, input key_buffer_size, output ready);
endinterface

[design/name_group_key_fnv1a_hash.sv]
// Group key hasher: turns an archive name into a 32-bit FNV-1a hash of its key.
// The req_bus channel carries the name one byte per beat; a zero byte ends it.
// The rsp_bus channel gives one beat per name: key_ok, key_hash and key_length.
// The csr_bus channel writes key_buffer_size; it is always ready and should be
// written only while no name is in progress.
// When a non-terminating byte releases a key character into the hash, the
// shared FNV step (xor and 32-bit multiply by the prime) runs in a state of
// its own, and the sequencer waits for it.
// After the terminator, the held-back tail bytes (up to four) are shifted out
// one by one unless they form a dropped extension, with an FNV step for each
// byte that enters the key; then the flush closes and the result register loads.
// The result sits in an output register; if the receiver stalls, the block
// finishes the name and then holds off new bytes until the slot frees.
// Reset (synchronous, active high) clears the name state, drops any pending
// result and sets key_buffer_size back to 256.
module name_group_key_fnv1a_hash import ngk_pkg::*; (
   input logic        clock,
   input logic        reset,
   ngk_req_if.sink    req_bus,
   ngk_rsp_if.source  rsp_bus,
   ngk_csr_if.sink    csr_bus
);

   ngk_state_type state_ff, state_in;

   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [BYTE_W-1:0]     pend_ff, pend_in;
   logic [BYTE_W-1:0]     tail_ff [TAIL_DEPTH];
   logic [BYTE_W-1:0]     tail_in [TAIL_DEPTH];
   logic [TAIL_CNT_W-1:0] tail_cnt_ff, tail_cnt_in;
   logic [TAIL_CNT_W-1:0] flush_left_ff, flush_left_in;
   logic [CNT_W-1:0]      bytes_ff, bytes_in;
   logic [CNT_W-1:0]      chars_ff, chars_in;
   logic                  under_ff, under_in;
   logic                  flushing_ff, flushing_in;
   logic [KBS_W-1:0]      kbs_ff, kbs_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [HASH_W-1:0]     rsp_hash_ff, rsp_hash_in;
   logic [KEY_LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic                  tk_under;
   logic                  tk_hash;
   logic                  is_ext;
   logic [KEY_LEN_W-1:0]  len_sat;

   // Decision for the byte at the head of the tail buffer.
   always_comb begin
      tk_under = !under_ff && (tail_ff[0] == CHAR_UNDERSCORE);
      tk_hash  = !under_ff && (tail_ff[0] != CHAR_UNDERSCORE) &&
                 is_alnum_ascii(tail_ff[0]) &&
                 (32'(chars_ff) + 32'd1 < 32'(kbs_ff));
   end

   // Extension test over the four held-back bytes.
   always_comb begin
      is_ext = (tail_cnt_ff == TAIL_CNT_W'(TAIL_DEPTH)) && (tail_ff[0] == CHAR_DOT) &&
               (lower_ascii(tail_ff[1]) == CHAR_L) &&
               (((lower_ascii(tail_ff[2]) == CHAR_H) && (lower_ascii(tail_ff[3]) == CHAR_A)) ||
                ((lower_ascii(tail_ff[2]) == CHAR_Z) && (lower_ascii(tail_ff[3]) == CHAR_X)));
   end

   // Key length saturates at the field's maximum.
   always_comb begin
      if (32'(chars_ff) > 32'(KEY_LEN_MAX)) begin
         len_sat = KEY_LEN_MAX;
      end else begin
         len_sat = KEY_LEN_W'(chars_ff);
      end
   end

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in      = state_ff;
      hash_in       = hash_ff;
      pend_in       = pend_ff;
      tail_in       = tail_ff;
      tail_cnt_in   = tail_cnt_ff;
      flush_left_in = flush_left_ff;
      bytes_in      = bytes_ff;
      chars_in      = chars_ff;
      under_in      = under_ff;
      flushing_in   = flushing_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_hash_in   = rsp_hash_ff;
      rsp_len_in    = rsp_len_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.name_byte != CHAR_NUL) begin
                  if (32'(bytes_ff) < 32'(NAME_BUFFER_SIZE - 1)) begin
                     bytes_in = bytes_ff + CNT_W'(1);
                     if (tail_cnt_ff < TAIL_CNT_W'(TAIL_DEPTH)) begin
                        tail_in[tail_cnt_ff[1:0]] = req_bus.name_byte;
                        tail_cnt_in = tail_cnt_ff + TAIL_CNT_W'(1);
                     end else begin
                        // The oldest held byte can no longer be part of an extension.
                        under_in = under_ff || tk_under;
                        tail_in[0] = tail_ff[1];
                        tail_in[1] = tail_ff[2];
                        tail_in[2] = tail_ff[3];
                        tail_in[3] = req_bus.name_byte;
                        if (tk_hash) begin
                           pend_in     = lower_ascii(tail_ff[0]);
                           chars_in    = chars_ff + CNT_W'(1);
                           flushing_in = 1'b0;
                           state_in    = ST_HASH;
                        end
                     end
                  end
               end else begin
                  // Terminator: drop a matching extension, else flush the tail.
                  flush_left_in = is_ext ? '0 : tail_cnt_ff;
                  state_in      = ST_FLUSH;
               end
            end
         end

         ST_HASH: begin
            // Shared FNV-1a step.
            hash_in  = (hash_ff ^ HASH_W'(pend_ff)) * FNV_PRIME;
            state_in = flushing_ff ? ST_FLUSH : ST_IDLE;
         end

         ST_FLUSH: begin
            if (flush_left_ff != '0) begin
               under_in      = under_ff || tk_under;
               tail_in[0]    = tail_ff[1];
               tail_in[1]    = tail_ff[2];
               tail_in[2]    = tail_ff[3];
               flush_left_in = flush_left_ff - TAIL_CNT_W'(1);
               if (tk_hash) begin
                  pend_in     = lower_ascii(tail_ff[0]);
                  chars_in    = chars_ff + CNT_W'(1);
                  flushing_in = 1'b1;
                  state_in    = ST_HASH;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // Load the result once the output slot is free, then start a new name.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = (chars_ff != '0);
               rsp_hash_in  = (chars_ff != '0) ? hash_ff : '0;
               rsp_len_in   = len_sat;
               hash_in      = FNV_BASIS;
               tail_cnt_in  = '0;
               bytes_in     = '0;
               chars_in     = '0;
               under_in     = 1'b0;
               flushing_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration register write.
   always_comb begin
      kbs_in = csr_bus.valid ? csr_bus.key_buffer_size : kbs_ff;
   end

   // Control state and registers with a reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hash_ff       <= FNV_BASIS;
         tail_cnt_ff   <= '0;
         flush_left_ff <= '0;
         bytes_ff      <= '0;
         chars_ff      <= '0;
         under_ff      <= 1'b0;
         flushing_ff   <= 1'b0;
         kbs_ff        <= KBS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hash_ff       <= hash_in;
         tail_cnt_ff   <= tail_cnt_in;
         flush_left_ff <= flush_left_in;
         bytes_ff      <= bytes_in;
         chars_ff      <= chars_in;
         under_ff      <= under_in;
         flushing_ff   <= flushing_in;
         kbs_ff        <= kbs_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      tail_ff     <= tail_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_len_ff  <= rsp_len_in;
   end

   // Port drive.
   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.key_ok     = rsp_ok_ff;
   assign rsp_bus.key_hash   = rsp_hash_ff;
   assign rsp_bus.key_length = rsp_len_ff;

   // Every key character comes from a byte that was taken.
   a_chars_le_bytes: assert property (@(posedge clock) disable iff (reset)
      chars_ff <= bytes_ff)
      else $error("key character count exceeds bytes taken");

   // A result reports ok exactly when its key is non-empty, with hash 0 otherwise.
   a_rsp_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ok_ff == (rsp_len_ff != '0)) && (rsp_ok_ff || rsp_hash_ff == '0))
      else $error("result fields disagree");

   // The tail never holds more than four bytes, and no more are left to flush than it holds.
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_cnt_ff <= TAIL_CNT_W'(TAIL_DEPTH) && flush_left_ff <= tail_cnt_ff)
      else $error("tail count out of range");

   // No flush work is left over once a new name may start.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (flush_left_ff == '0))
      else $error("flush pending while idle");

endmodule
